FILE: rtl/core/arpc_pkg.sv
// Shared types and constants for the ARP cache and responder.
// Used by arpc_cell and arp_cache_and_responder; depends on nothing.
package arpc_pkg;

  localparam int IP_W    = 32;
  localparam int MAC_W   = 48;
  localparam int STAMP_W = 48;

  // request kinds
  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_ARP    = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  // configuration register indexes
  localparam logic CFG_LOCAL_IP  = 1'b0;
  localparam logic CFG_LOCAL_MAC = 1'b1;

  // header checks
  localparam logic [10:0] MIN_ARP_LEN  = 11'd28;
  localparam logic [15:0] HTYPE_ETH    = 16'h0001;
  localparam logic [15:0] PTYPE_IPV4   = 16'h0800;
  localparam logic [7:0]  HLEN_MAC     = 8'd6;
  localparam logic [7:0]  PLEN_IPV4    = 8'd4;
  localparam logic [15:0] OPER_REQUEST = 16'd1;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [10:0]        pkt_len;
    logic [15:0]        hw_type;
    logic [15:0]        proto_type;
    logic [7:0]         hw_addr_len;
    logic [7:0]         proto_addr_len;
    logic [15:0]        operation;
    logic [MAC_W-1:0]   sender_mac;
    logic [IP_W-1:0]    sender_ip;
    logic [IP_W-1:0]    tgt_ip;
    logic [IP_W-1:0]    lookup_ip;
    logic [STAMP_W-1:0] now_ms;
  } in_req_t;

  typedef struct packed {
    logic             hit;
    logic [MAC_W-1:0] found_mac;
    logic             accepted;
    logic             send_reply;
    logic [MAC_W-1:0] reply_to_mac;
    logic [IP_W-1:0]  reply_to_ip;
  } out_res_t;

  // Search token that walks the cell row, one cell per cycle.
  typedef struct packed {
    logic               act;
    logic [IP_W-1:0]    key;
    logic               hit;
    logic [MAC_W-1:0]   mac;
    logic               free;
    logic [STAMP_W-1:0] old_stamp;
  } probe_t;

  // Broadcast update to all cells; the target index travels beside it.
  typedef struct packed {
    logic               en;
    logic               clr;
    logic [IP_W-1:0]    ip;
    logic [MAC_W-1:0]   mac;
    logic [STAMP_W-1:0] stamp;
  } wr_cmd_t;

endpackage

FILE: rtl/core/arp_cache_and_responder.sv
// ARP cache with reply offload: top level, a row of CACHE_ENTRIES arpc_cell stages.
// One request at a time: a new request is taken only once the previous one has completed,
// after its search token has walked the cell row one entry per cycle; a waiting result
// stalls the next completion.
// Reset (synchronous, rst_n low): all entries invalid and zero, local_ip zero, idle.
// Depends on arpc_pkg and arpc_cell.
module arp_cache_and_responder import arpc_pkg::*; #(
  parameter int CACHE_ENTRIES = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  // request channel
  input  logic             in_valid,
  output logic             in_stall,
  input  in_req_t          in_data,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output out_res_t         out_data,
  // configuration writes
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [MAC_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(CACHE_ENTRIES);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LAUNCH = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_DONE   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  in_req_t         item_r;
  logic [IP_W-1:0] local_ip_r;

  // search row wiring: element k feeds cell k, element CACHE_ENTRIES is the tail
  probe_t           probe_w    [CACHE_ENTRIES+1];
  logic [IDX_W-1:0] hit_idx_w  [CACHE_ENTRIES+1];
  logic [IDX_W-1:0] free_idx_w [CACHE_ENTRIES+1];
  logic [IDX_W-1:0] old_idx_w  [CACHE_ENTRIES+1];

  probe_t           tail_r;
  logic [IDX_W-1:0] tail_hit_idx_r, tail_free_idx_r, tail_old_idx_r;

  wr_cmd_t          wr;
  logic [IDX_W-1:0] wr_idx;

  out_res_t out_r, res_nxt;
  logic     out_valid_r, out_valid_nxt;

  logic in_accept, can_load, finish, hdr_ok;

  // ---------------------------------------------------------------------------
  // Handshakes. Take a request only when idle; hold completion while a result
  // still waits downstream.
  // ---------------------------------------------------------------------------
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign can_load  = !out_valid_r || !out_stall;
  assign finish    = (state_r == ST_DONE) && can_load;
  assign cfg_ready = 1'b1;

  // Configuration: local_mac is not used in this block, so drop it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_ip_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LOCAL_IP:  local_ip_r <= cfg_data[IP_W-1:0];
        CFG_LOCAL_MAC: ;
        default:       ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: IDLE -> LAUNCH (inject token) -> SCAN (token walks the row)
  // -> DONE (apply cache update and load result) -> IDLE.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_accept) state_nxt = ST_LAUNCH;
      ST_LAUNCH: state_nxt = ST_SCAN;
      ST_SCAN:   if (probe_w[CACHE_ENTRIES].act) state_nxt = ST_DONE;
      ST_DONE:   if (can_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r <= in_data;
    end
  end

  // Seed the token: lookups search lookup_ip, all other kinds search sender_ip.
  always_comb begin
    probe_w[0]           = '0;
    probe_w[0].act       = (state_r == ST_LAUNCH);
    probe_w[0].key       = (item_r.req_type == REQ_LOOKUP) ? item_r.lookup_ip
                                                            : item_r.sender_ip;
    hit_idx_w[0]         = '0;
    free_idx_w[0]        = '0;
    old_idx_w[0]         = '0;
  end

  for (genvar g = 0; g < CACHE_ENTRIES; g++) begin : g_cell
    arpc_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (g)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .wr           (wr),
      .wr_idx       (wr_idx),
      .probe_in     (probe_w[g]),
      .hit_idx_in   (hit_idx_w[g]),
      .free_idx_in  (free_idx_w[g]),
      .old_idx_in   (old_idx_w[g]),
      .probe_out    (probe_w[g+1]),
      .hit_idx_out  (hit_idx_w[g+1]),
      .free_idx_out (free_idx_w[g+1]),
      .old_idx_out  (old_idx_w[g+1])
    );
  end

  // Capture the token as it leaves the last cell.
  always_ff @(posedge clk) begin
    if (probe_w[CACHE_ENTRIES].act) begin
      tail_r          <= probe_w[CACHE_ENTRIES];
      tail_hit_idx_r  <= hit_idx_w[CACHE_ENTRIES];
      tail_free_idx_r <= free_idx_w[CACHE_ENTRIES];
      tail_old_idx_r  <= old_idx_w[CACHE_ENTRIES];
    end
  end

  // ---------------------------------------------------------------------------
  // Completion: header checks, slot choice (matching entry, else first free,
  // else oldest stamp), reply decision and result fields.
  // ---------------------------------------------------------------------------
  assign hdr_ok = (item_r.pkt_len >= MIN_ARP_LEN) &&
                  (item_r.hw_type == HTYPE_ETH) &&
                  (item_r.proto_type == PTYPE_IPV4) &&
                  (item_r.hw_addr_len == HLEN_MAC) &&
                  (item_r.proto_addr_len == PLEN_IPV4);

  always_comb begin
    res_nxt  = '0;
    wr       = '0;
    wr.ip    = item_r.sender_ip;
    wr.mac   = item_r.sender_mac;
    wr.stamp = item_r.now_ms;
    wr_idx   = tail_r.hit  ? tail_hit_idx_r :
               tail_r.free ? tail_free_idx_r : tail_old_idx_r;
    unique case (item_r.req_type)
      REQ_LOOKUP: begin
        res_nxt.hit       = tail_r.hit;
        res_nxt.found_mac = tail_r.hit ? tail_r.mac : '0;
      end
      REQ_ARP: begin
        if (hdr_ok) begin
          wr.en            = finish;
          res_nxt.accepted = 1'b1;
          if (item_r.operation == OPER_REQUEST && item_r.tgt_ip == local_ip_r) begin
            res_nxt.send_reply   = 1'b1;
            res_nxt.reply_to_mac = item_r.sender_mac;
            res_nxt.reply_to_ip  = item_r.sender_ip;
          end
        end
      end
      REQ_CLEAR: begin
        wr.clr = finish;
      end
      default: ;
    endcase
  end

  // Output register: load on completion, drop once taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    probe_w[CACHE_ENTRIES].act |-> state_r == ST_SCAN)
    else $error("search token left the row outside the scan phase");

  a_accept_launch: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> state_r == ST_LAUNCH)
    else $error("accepted request did not launch a search");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised without a completed search");

endmodule

FILE: rtl/core/arpc_cell.sv
// One cache entry of the ARP cache plus its stage of the search row.
// Depends on arpc_pkg for the probe and update types.
module arpc_cell import arpc_pkg::*; #(
  parameter int IDX_W    = 3,
  parameter int CELL_IDX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  wr_cmd_t          wr,
  input  logic [IDX_W-1:0] wr_idx,
  input  probe_t           probe_in,
  input  logic [IDX_W-1:0] hit_idx_in,
  input  logic [IDX_W-1:0] free_idx_in,
  input  logic [IDX_W-1:0] old_idx_in,
  output probe_t           probe_out,
  output logic [IDX_W-1:0] hit_idx_out,
  output logic [IDX_W-1:0] free_idx_out,
  output logic [IDX_W-1:0] old_idx_out
);

  localparam logic [IDX_W-1:0] MY_IDX   = IDX_W'(CELL_IDX);
  localparam bit               IS_FIRST = (CELL_IDX == 0);

  logic               valid_r;
  logic [IP_W-1:0]    ip_r;
  logic [MAC_W-1:0]   mac_r;
  logic [STAMP_W-1:0] stamp_r;

  probe_t           probe_r, probe_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic [IDX_W-1:0] old_idx_r, old_idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      ip_r    <= '0;
      mac_r   <= '0;
      stamp_r <= '0;
    end else if (wr.clr) begin
      valid_r <= 1'b0;
    end else if (wr.en && wr_idx == MY_IDX) begin
      valid_r <= 1'b1;
      ip_r    <= wr.ip;
      mac_r   <= wr.mac;
      stamp_r <= wr.stamp;
    end
  end

  always_comb begin
    probe_nxt    = probe_in;
    hit_idx_nxt  = hit_idx_in;
    free_idx_nxt = free_idx_in;
    old_idx_nxt  = old_idx_in;
    if (probe_in.act) begin
      // first matching entry wins
      if (!probe_in.hit && valid_r && ip_r == probe_in.key) begin
        probe_nxt.hit = 1'b1;
        probe_nxt.mac = mac_r;
        hit_idx_nxt   = MY_IDX;
      end
      if (!probe_in.free && !valid_r) begin
        probe_nxt.free = 1'b1;
        free_idx_nxt   = MY_IDX;
      end
      // strict compare keeps the lowest index on ties
      if (IS_FIRST || stamp_r < probe_in.old_stamp) begin
        probe_nxt.old_stamp = stamp_r;
        old_idx_nxt         = MY_IDX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r <= '0;
    end else begin
      probe_r <= probe_nxt;
    end
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
    old_idx_r  <= old_idx_nxt;
  end

  assign probe_out    = probe_r;
  assign hit_idx_out  = hit_idx_r;
  assign free_idx_out = free_idx_r;
  assign old_idx_out  = old_idx_r;

endmodule

FILE: sim/tb_arp_cache_and_responder.sv
// Self-checking testbench for arp_cache_and_responder: lookups, learned ARP headers,
// replies to requests for the own address, oldest-stamp eviction and clears, under idle and stall.
// Depends on arpc_pkg and the RTL of arp_cache_and_responder.
module tb_arp_cache_and_responder;
  import arpc_pkg::*;

  localparam int N_ENTRIES = 8;
  // Accept to result, for the token that walks the whole row.
  localparam int LATENCY   = N_ENTRIES + 2;
  localparam int POOL      = 12;

  // Request kind that the block must ignore.
  localparam logic [1:0]  REQ_UNUSED = 2'd3;
  localparam logic [15:0] OPER_REPLY = 16'd2;
  localparam logic [47:0] ALL_MAC    = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] ALL_IP     = 32'hFFFF_FFFF;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_req_t          in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_res_t         out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic             cfg_index = 1'b0;
  logic [MAC_W-1:0] cfg_data  = '0;

  arp_cache_and_responder #(.CACHE_ENTRIES(N_ENTRIES)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Our own copy of the cache, advanced at every accepted request, and of the registers.
  logic               slot_valid [N_ENTRIES];
  logic [IP_W-1:0]    slot_ip    [N_ENTRIES];
  logic [MAC_W-1:0]   slot_mac   [N_ENTRIES];
  logic [STAMP_W-1:0] slot_stamp [N_ENTRIES];
  logic [IP_W-1:0]    own_ip  = '0;
  logic [MAC_W-1:0]   own_mac = '0;

  // Answers the block owes us, oldest first.
  out_res_t awaited_answers[$];

  // Small address pool so that learns hit existing entries and overflow the cache.
  logic [IP_W-1:0] ip_pool [POOL];

  int gap_pct    = 0;
  int stall_pct  = 0;
  int fail_count = 0;
  int n_requests = 0;
  int n_checked  = 0;
  int n_hits     = 0;
  int n_learned  = 0;
  int n_replies  = 0;
  int n_dropped  = 0;

  initial begin
    for (int i = 0; i < N_ENTRIES; i++) begin
      slot_valid[i] = 1'b0;
      slot_ip[i]    = '0;
      slot_mac[i]   = '0;
      slot_stamp[i] = '0;
    end
  end

  // Compute the answer for one accepted request and update the cache copy.
  function automatic out_res_t arp_cache_answer(input in_req_t req);
    out_res_t ans;
    int       victim;
    logic     found;
    ans    = '0;
    victim = -1;
    found  = 1'b0;
    case (req.req_type)
      REQ_LOOKUP: begin
        for (int i = 0; i < N_ENTRIES; i++) begin
          if (!found && slot_valid[i] && slot_ip[i] == req.lookup_ip) begin
            found         = 1'b1;
            ans.hit       = 1'b1;
            ans.found_mac = slot_mac[i];
          end
        end
        if (found) n_hits++;
      end
      REQ_ARP: begin
        if (req.pkt_len >= MIN_ARP_LEN && req.hw_type == HTYPE_ETH &&
            req.proto_type == PTYPE_IPV4 && req.hw_addr_len == HLEN_MAC &&
            req.proto_addr_len == PLEN_IPV4) begin
          // Reuse the entry of this address, else the first free one,
          // else the oldest stamp with ties to the lowest index.
          for (int i = 0; i < N_ENTRIES; i++)
            if (victim < 0 && slot_valid[i] && slot_ip[i] == req.sender_ip) victim = i;
          for (int i = 0; i < N_ENTRIES; i++)
            if (victim < 0 && !slot_valid[i]) victim = i;
          if (victim < 0) begin
            victim = 0;
            for (int i = 1; i < N_ENTRIES; i++)
              if (slot_stamp[i] < slot_stamp[victim]) victim = i;
          end
          slot_valid[victim] = 1'b1;
          slot_ip[victim]    = req.sender_ip;
          slot_mac[victim]   = req.sender_mac;
          slot_stamp[victim] = req.now_ms;
          ans.accepted = 1'b1;
          n_learned++;
          if (req.operation == OPER_REQUEST && req.tgt_ip == own_ip) begin
            ans.send_reply   = 1'b1;
            ans.reply_to_mac = req.sender_mac;
            ans.reply_to_ip  = req.sender_ip;
            n_replies++;
          end
        end else begin
          n_dropped++;
        end
      end
      REQ_CLEAR: begin
        for (int i = 0; i < N_ENTRIES; i++) slot_valid[i] = 1'b0;
      end
      default: ;
    endcase
    return ans;
  endfunction

  // Every field random: the noise that fills fields a request kind does not use.
  function automatic in_req_t random_fields();
    logic [287:0] noise;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom};
    return noise[$bits(in_req_t)-1:0];
  endfunction

  function automatic logic [IP_W-1:0] pool_ip();
    return ip_pool[$urandom_range(POOL - 1)];
  endfunction

  // A well-formed header with the given operation, addresses and stamp; the rest is zero.
  function automatic in_req_t arp_header(input logic [15:0] op, input logic [MAC_W-1:0] smac,
                                         input logic [IP_W-1:0] sip, input logic [IP_W-1:0] tip,
                                         input logic [STAMP_W-1:0] stamp);
    in_req_t r;
    r                = '0;
    r.req_type       = REQ_ARP;
    r.pkt_len        = MIN_ARP_LEN;
    r.hw_type        = HTYPE_ETH;
    r.proto_type     = PTYPE_IPV4;
    r.hw_addr_len    = HLEN_MAC;
    r.proto_addr_len = PLEN_IPV4;
    r.operation      = op;
    r.sender_mac     = smac;
    r.sender_ip      = sip;
    r.tgt_ip         = tip;
    r.now_ms         = stamp;
    return r;
  endfunction

  function automatic in_req_t lookup_of(input logic [IP_W-1:0] ip);
    in_req_t r;
    r           = '0;
    r.req_type  = REQ_LOOKUP;
    r.lookup_ip = ip;
    return r;
  endfunction

  // Mostly well-formed traffic over the pool, with broken headers and noise mixed in.
  function automatic in_req_t random_request();
    in_req_t r;
    int      pick;
    r    = random_fields();
    pick = $urandom_range(99);
    if (pick < 36) begin
      r.req_type = REQ_LOOKUP;
      if ($urandom_range(9) < 7) r.lookup_ip = pool_ip();
    end else if (pick < 94) begin
      r.req_type       = REQ_ARP;
      r.pkt_len        = ($urandom_range(3) == 0) ? MIN_ARP_LEN : 11'($urandom_range(2047, 28));
      r.hw_type        = HTYPE_ETH;
      r.proto_type     = PTYPE_IPV4;
      r.hw_addr_len    = HLEN_MAC;
      r.proto_addr_len = PLEN_IPV4;
      pick = $urandom_range(99);
      if (pick < 75) r.operation = OPER_REQUEST;
      else if (pick < 88) r.operation = OPER_REPLY;
      if ($urandom_range(9) < 8) r.sender_ip = pool_ip();
      pick = $urandom_range(9);
      if (pick < 4) r.tgt_ip = own_ip;
      else if (pick < 7) r.tgt_ip = pool_ip();
      // Small stamps give ties for the eviction choice.
      if ($urandom_range(1) == 0) r.now_ms = 48'($urandom_range(15));
      // Break one check in about one header of five.
      if ($urandom_range(9) >= 8) begin
        case ($urandom_range(4))
          0: r.pkt_len = 11'($urandom_range(27));
          1: r.hw_type = r.hw_type ^ (16'd1 << $urandom_range(15));
          2: r.proto_type = r.proto_type ^ (16'd1 << $urandom_range(15));
          3: r.hw_addr_len = r.hw_addr_len ^ (8'd1 << $urandom_range(7));
          default: r.proto_addr_len = r.proto_addr_len ^ (8'd1 << $urandom_range(7));
        endcase
      end
    end else if (pick < 96) begin
      r.req_type = REQ_CLEAR;
    end else begin
      r.req_type = REQ_UNUSED;
    end
    return r;
  endfunction

  // Send one request: idle at random first, then hold it until the block takes it.
  task automatic send_request(input in_req_t req);
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    awaited_answers.push_back(arp_cache_answer(req));
    n_requests++;
  endtask

  // Drop valid and wait until every answer is in and the row has gone quiet.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (awaited_answers.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // Write one register; callers only do this while the block is idle.
  task automatic write_register(input logic idx, input logic [MAC_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_LOCAL_IP) own_ip = value[IP_W-1:0];
    else own_mac = value;
    @(posedge clk);
  endtask

  task automatic report_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch on %s: expected %h, got %h", name, want, got);
    end
  endtask

  // Random back-pressure on the result channel.
  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // Check each accepted answer against the oldest prediction, field by field.
  always @(posedge clk) begin : result_check
    out_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_answers.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected answer %h with nothing awaited", out_data);
      end else begin
        want = awaited_answers.pop_front();
        n_checked++;
        report_field("hit", 64'(want.hit), 64'(out_data.hit));
        report_field("found_mac", 64'(want.found_mac), 64'(out_data.found_mac));
        report_field("accepted", 64'(want.accepted), 64'(out_data.accepted));
        report_field("send_reply", 64'(want.send_reply), 64'(out_data.send_reply));
        report_field("reply_to_mac", 64'(want.reply_to_mac), 64'(out_data.reply_to_mac));
        report_field("reply_to_ip", 64'(want.reply_to_ip), 64'(out_data.reply_to_ip));
      end
    end
  end

  // Lookup on an empty cache, one good header, then each header check failing alone.
  task automatic test_header_checks();
    in_req_t bad;
    send_request(lookup_of('0));
    send_request(arp_header(OPER_REQUEST, ALL_MAC, ip_pool[2], own_ip, ALL_MAC));
    bad = arp_header(OPER_REQUEST, 48'h0A0B_0C0D_0E0F, ip_pool[5], own_ip, 48'd1);
    bad.pkt_len = MIN_ARP_LEN - 11'd1;
    send_request(bad);
    bad.pkt_len = MIN_ARP_LEN;
    bad.hw_type = 16'hFFFF;
    send_request(bad);
    bad.hw_type    = HTYPE_ETH;
    bad.proto_type = PTYPE_IPV4 ^ 16'h0001;
    send_request(bad);
    bad.proto_type  = PTYPE_IPV4;
    bad.hw_addr_len = HLEN_MAC + 8'd1;
    send_request(bad);
    bad.hw_addr_len    = HLEN_MAC;
    bad.proto_addr_len = PLEN_IPV4 + 8'd1;
    send_request(bad);
  endtask

  // Replies learn without answering, requests for others too; relearn updates in place.
  task automatic test_learning_and_reply();
    in_req_t hdr;
    hdr = arp_header(OPER_REPLY, 48'h1111_2222_3333, ALL_IP, own_ip, '0);
    hdr.pkt_len = 11'd2047;
    send_request(hdr);
    send_request(arp_header(OPER_REQUEST, 48'h4444_5555_6666, ip_pool[3], ~own_ip, 48'd7));
    send_request(lookup_of(ip_pool[2]));
    send_request(arp_header(OPER_REQUEST, '0, ip_pool[2], own_ip, 48'd3));
    send_request(lookup_of(ip_pool[2]));
  endtask

  // Fill the cache with tied stamps, then overflow it; the oldest lowest entry goes.
  task automatic test_eviction();
    logic [STAMP_W-1:0] stamps [5];
    stamps = '{48'd0, 48'd0, 48'd9, 48'd9, 48'd2};
    for (int i = 0; i < 5; i++)
      send_request(arp_header(OPER_REPLY, 48'(32'hC0DE_0000 + i), ip_pool[6 + i],
                              ip_pool[0], stamps[i]));
    send_request(arp_header(OPER_REPLY, 48'hFEED_FACE_0001, ip_pool[11], ip_pool[0], 48'd20));
    send_request(lookup_of(ALL_IP));
  endtask

  // Clear drops only the valid bits; the unused kind leaves the cache alone.
  task automatic test_clear_and_unused_kind();
    in_req_t req;
    req = random_fields();
    req.req_type = REQ_CLEAR;
    send_request(req);
    send_request(lookup_of(ip_pool[3]));
    req = random_fields();
    req.req_type = REQ_UNUSED;
    send_request(req);
    send_request(arp_header(OPER_REQUEST, 48'h0123_4567_89AB, ip_pool[3], own_ip, ALL_MAC));
    send_request(lookup_of(ip_pool[3]));
  endtask

  // One phase of random traffic under the given idle and stall rates and register values.
  task automatic test_random_traffic(input int count, input int gap, input int stall,
                                     input logic [IP_W-1:0] lip, input logic [MAC_W-1:0] lmac);
    wait_for_results();
    gap_pct   = gap;
    stall_pct = stall;
    write_register(CFG_LOCAL_IP, MAC_W'(lip));
    write_register(CFG_LOCAL_MAC, lmac);
    for (int n = 0; n < count; n++) send_request(random_request());
  endtask

  initial begin
    ip_pool[0] = '0;
    ip_pool[1] = ALL_IP;
    for (int i = 2; i < POOL; i++) ip_pool[i] = $urandom;

    // Hold reset, then release it once.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_register(CFG_LOCAL_IP, MAC_W'(ip_pool[4]));
    write_register(CFG_LOCAL_MAC, '0);
    test_header_checks();
    test_learning_and_reply();
    test_eviction();
    test_clear_and_unused_kind();

    test_random_traffic(350, 0, 0, ALL_IP, ALL_MAC);
    test_random_traffic(350, 84, 0, '0, 48'({$urandom, $urandom}));
    test_random_traffic(350, 0, 84, ip_pool[5], '0);
    test_random_traffic(350, 31, 31, $urandom, 48'({$urandom, $urandom}));
    wait_for_results();

    if (awaited_answers.size() != 0)
      $display("%0d answers never arrived", awaited_answers.size());
    $display("sent %0d requests over four idle/stall phases and five register settings",
             n_requests);
    $display("checked %0d answers: %0d hits, %0d learned, %0d replies, %0d dropped headers",
             n_checked, n_hits, n_learned, n_replies, n_dropped);
    if (fail_count == 0 && awaited_answers.size() == 0) begin
      $display("PASS arp_cache_and_responder");
    end else begin
      $display("FAIL arp_cache_and_responder");
    end
    $finish;
  end

  // Stop a hung run well past the slowest correct one.
  initial begin
    #5_000_000;
    $display("FAIL arp_cache_and_responder");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/arpc_pkg.sv
rtl/core/arpc_cell.sv
rtl/core/arp_cache_and_responder.sv
sim/tb_arp_cache_and_responder.sv
